>>> sv/msidx_pkg.sv
// msidx_pkg: shared constants and the command record for the segment index parser
// depends on nothing; used by every module of the block
`default_nettype none

package msidx_pkg;

    localparam int DUR_FRAC_BITS_DEF = 16;
    localparam int DUR_WIDTH         = 48;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [31:0] TAG_SIDX = 32'h7369_6478;
    localparam logic [31:0] TAG_MOOV = 32'h6D6F_6F76;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_FINISH  = 1'b1;

    // one queue entry: optionally a segment to finish, optionally the end record
    typedef struct packed {
        logic        has_seg;
        logic        has_fin;
        logic [63:0] seg_begin;
        logic [30:0] seg_length;
        logic [31:0] ticks;
        logic [31:0] scale;
        logic [63:0] movie_end;
    } cmd_t;

endpackage

`default_nettype wire

>>> sv/msidx_if.sv
// msidx_if: valid/ready channel interfaces for the byte input and the record output
// no dependencies
`default_nettype none

interface msidx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface msidx_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [63:0] seg_begin;
    logic [30:0] seg_length;
    logic [47:0] seg_duration;
    logic [63:0] movie_end_pos;
    logic        is_last;

    modport source (output valid, output record_kind, output seg_begin, output seg_length,
                    output seg_duration, output movie_end_pos, output is_last, input ready);
    modport sink   (input valid, input record_kind, input seg_begin, input seg_length,
                    input seg_duration, input movie_end_pos, input is_last, output ready);
endinterface

`default_nettype wire

>>> sv/mp4_segment_index_parser.sv
// mp4_segment_index_parser: top level of the fragmented MP4 segment index parser
// depends on msidx_pkg, msidx_if, msidx_front, msidx_queue, msidx_back
`default_nettype none

// Takes a file one byte per transaction (one byte a cycle while the command queue has
// room) and emits one record per media reference of each sidx box (none after the first
// non-media reference in a box), then a final record with the movie box end on the
// end-of-stream byte. The back end computes each segment's duration with a bit-serial
// restoring divider that turns ticks into 32.16 seconds; a four-entry command queue
// lets the byte walker run ahead while a division is under way.

module mp4_segment_index_parser #(
    parameter int DUR_FRAC_BITS = msidx_pkg::DUR_FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    msidx_in_if.sink   in,
    msidx_out_if.source out
);

    msidx_pkg::cmd_t push_cmd;
    msidx_pkg::cmd_t head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    msidx_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in.valid),
        .in_ready      (in.ready),
        .data_byte     (in.data_byte),
        .end_of_stream (in.end_of_stream),
        .q_full        (q_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    msidx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    msidx_back #(
        .DUR_FRAC_BITS (DUR_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (pop),
        .out_valid     (out.valid),
        .out_ready     (out.ready),
        .record_kind   (out.record_kind),
        .seg_begin     (out.seg_begin),
        .seg_length    (out.seg_length),
        .seg_duration  (out.seg_duration),
        .movie_end_pos (out.movie_end_pos),
        .is_last       (out.is_last)
    );

endmodule

`default_nettype wire

>>> sv/msidx_front.sv
// msidx_front: byte walker over the top-level boxes and the sidx fields
// depends on msidx_pkg; pushes commands into msidx_queue
`default_nettype none

module msidx_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_stream,
    input  wire logic          q_full,
    output logic               push,
    output msidx_pkg::cmd_t    push_cmd
);

    typedef enum logic [3:0] {
        PH_HDR, PH_SKIP, PH_VER, PH_TRACK, PH_TSCALE, PH_EPT, PH_FOFF,
        PH_RESV, PH_COUNT, PH_RSIZE, PH_RDUR, PH_RSAP, PH_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [63:0] pos_reg, pos_next;
    logic [63:0] box_start_reg, box_start_next;
    logic [31:0] box_len_reg, box_len_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ver_reg, ver_next;
    logic [31:0] scale_reg, scale_next;
    logic [15:0] refs_reg, refs_next;
    logic        media_reg, media_next;
    logic [63:0] begin_reg, begin_next;
    logic [30:0] size_reg, size_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [31:0] skip_reg, skip_next;
    logic [63:0] mend_reg, mend_next;

    logic        fire;
    logic [63:0] v;
    logic [3:0]  cnt_inc;
    logic [3:0]  flen;
    logic        emit_seg;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign v        = {shift_reg[55:0], data_byte};
    assign cnt_inc  = cnt_reg + 4'd1;

    always_comb
    begin
        unique case (phase_reg)
            PH_HDR:             flen = 4'd8;
            PH_EPT, PH_FOFF:    flen = ver_reg ? 4'd8 : 4'd4;
            PH_RESV, PH_COUNT:  flen = 4'd2;
            default:            flen = 4'd4;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        box_start_next = box_start_reg;
        box_len_next   = box_len_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        ver_next       = ver_reg;
        scale_next     = scale_reg;
        refs_next      = refs_reg;
        media_next     = media_reg;
        begin_next     = begin_reg;
        size_next      = size_reg;
        ticks_next     = ticks_reg;
        skip_next      = skip_reg;
        mend_next      = mend_reg;
        emit_seg       = 1'b0;
        if (fire)
        begin
            pos_next = pos_reg + 64'd1;
            if (phase_reg == PH_SKIP)
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_reg == 32'd1)
                    phase_next = PH_HDR;
            end
            else if (phase_reg != PH_STOP)
            begin
                if (phase_reg == PH_HDR && cnt_reg == 4'd0)
                    box_start_next = pos_reg;
                shift_next = v;
                cnt_next   = cnt_inc;
                if (cnt_inc >= flen)
                begin
                    shift_next = 64'd0;
                    cnt_next   = 4'd0;
                    unique case (phase_reg)
                        PH_HDR:
                        begin
                            box_len_next = v[63:32];
                            if (v[63:32] < 32'd8)
                                phase_next = PH_STOP;
                            else if (v[31:0] == msidx_pkg::TAG_SIDX)
                            begin
                                media_next = 1'b1;
                                phase_next = PH_VER;
                            end
                            else
                            begin
                                if (v[31:0] == msidx_pkg::TAG_MOOV)
                                    mend_next = box_start_reg + {32'd0, v[63:32]} + 64'd1;
                                skip_next  = v[63:32] - 32'd8;
                                phase_next = (v[63:32] != 32'd8) ? PH_SKIP : PH_HDR;
                            end
                        end
                        PH_VER:
                        begin
                            ver_next   = v[31:24] != 8'd0;
                            phase_next = PH_TRACK;
                        end
                        PH_TRACK:  phase_next = PH_TSCALE;
                        PH_TSCALE:
                        begin
                            scale_next = v[31:0];
                            phase_next = PH_EPT;
                        end
                        PH_EPT:    phase_next = PH_FOFF;
                        PH_FOFF:
                        begin
                            begin_next = box_start_reg + {32'd0, box_len_reg} + v;
                            phase_next = PH_RESV;
                        end
                        PH_RESV:   phase_next = PH_COUNT;
                        PH_COUNT:
                        begin
                            refs_next  = v[15:0];
                            phase_next = (v[15:0] != 16'd0) ? PH_RSIZE : PH_HDR;
                        end
                        PH_RSIZE:
                        begin
                            if (v[31])
                                media_next = 1'b0;
                            size_next  = v[30:0];
                            phase_next = PH_RDUR;
                        end
                        PH_RDUR:
                        begin
                            ticks_next = v[31:0];
                            phase_next = PH_RSAP;
                        end
                        default:
                        begin
                            emit_seg   = media_reg;
                            begin_next = begin_reg + {33'd0, size_reg};
                            refs_next  = refs_reg - 16'd1;
                            phase_next = (refs_reg != 16'd1) ? PH_RSIZE : PH_HDR;
                        end
                    endcase
                end
            end
            // end of stream: back to the reset state for the next file
            if (end_of_stream)
            begin
                phase_next     = PH_HDR;
                pos_next       = 64'd0;
                box_start_next = 64'd0;
                box_len_next   = 32'd0;
                shift_next     = 64'd0;
                cnt_next       = 4'd0;
                ver_next       = 1'b0;
                scale_next     = 32'd0;
                refs_next      = 16'd0;
                media_next     = 1'b1;
                begin_next     = 64'd0;
                size_next      = 31'd0;
                ticks_next     = 32'd0;
                skip_next      = 32'd0;
                mend_next      = '1;
            end
        end
    end

    always_comb
    begin
        push               = fire && (emit_seg || end_of_stream);
        push_cmd.has_seg   = emit_seg;
        push_cmd.has_fin   = end_of_stream;
        push_cmd.seg_begin = begin_reg;
        push_cmd.seg_length = size_reg;
        push_cmd.ticks     = ticks_reg;
        push_cmd.scale     = scale_reg;
        // the end record carries the movie end as left by this transaction
        push_cmd.movie_end = (phase_reg == PH_HDR && cnt_inc >= flen && fire
                              && v[63:32] >= 32'd8 && v[31:0] == msidx_pkg::TAG_MOOV)
                             ? box_start_reg + {32'd0, v[63:32]} + 64'd1 : mend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            pos_reg       <= 64'd0;
            box_start_reg <= 64'd0;
            box_len_reg   <= 32'd0;
            shift_reg     <= 64'd0;
            cnt_reg       <= 4'd0;
            ver_reg       <= 1'b0;
            scale_reg     <= 32'd0;
            refs_reg      <= 16'd0;
            media_reg     <= 1'b1;
            begin_reg     <= 64'd0;
            size_reg      <= 31'd0;
            ticks_reg     <= 32'd0;
            skip_reg      <= 32'd0;
            mend_reg      <= '1;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            box_start_reg <= box_start_next;
            box_len_reg   <= box_len_next;
            shift_reg     <= shift_next;
            cnt_reg       <= cnt_next;
            ver_reg       <= ver_next;
            scale_reg     <= scale_next;
            refs_reg      <= refs_next;
            media_reg     <= media_next;
            begin_reg     <= begin_next;
            size_reg      <= size_next;
            ticks_reg     <= ticks_next;
            skip_reg      <= skip_next;
            mend_reg      <= mend_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/msidx_queue.sv
// msidx_queue: short command queue between the byte walker and the divider side
// depends on msidx_pkg
`default_nettype none

module msidx_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire msidx_pkg::cmd_t  push_cmd,
    input  wire logic             pop,
    output msidx_pkg::cmd_t       head,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = $clog2(msidx_pkg::QUEUE_DEPTH);

    msidx_pkg::cmd_t mem_reg [msidx_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     fill_reg, fill_next;

    assign full  = fill_reg == (PW+1)'(msidx_pkg::QUEUE_DEPTH);
    assign empty = fill_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? wr_reg + 1'b1 : wr_reg;
        rd_next   = pop ? rd_reg + 1'b1 : rd_reg;
        fill_next = fill_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
        else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command popped from an empty queue");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (PW+1)'(msidx_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

`default_nettype wire

>>> sv/msidx_back.sv
// msidx_back: duration divider and output record register
// depends on msidx_pkg; takes commands from msidx_queue
`default_nettype none

module msidx_back #(
    parameter int DUR_FRAC_BITS = msidx_pkg::DUR_FRAC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msidx_pkg::cmd_t  head,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  record_kind,
    output logic [63:0]           seg_begin,
    output logic [30:0]           seg_length,
    output logic [47:0]           seg_duration,
    output logic [63:0]           movie_end_pos,
    output logic                  is_last
);

    localparam int DW = 32 + DUR_FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int OW = msidx_pkg::DUR_WIDTH;

    typedef enum logic [1:0] { B_IDLE, B_DIV, B_SEG, B_FIN } bstate_t;

    bstate_t         state_reg, state_next;
    msidx_pkg::cmd_t cmd_reg, cmd_next;
    logic [DW-1:0]   dvd_reg, dvd_next;
    logic [31:0]     rem_reg, rem_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [OW-1:0]   dur_reg, dur_next;
    logic [32:0]     rem_sh;
    logic            ge;
    logic [DW-1:0]   q_last;

    assign rem_sh = {rem_reg, dvd_reg[DW-1]};
    assign ge     = rem_sh >= {1'b0, cmd_reg.scale};
    // quotient bits shift into the dividend register from the bottom
    assign q_last = {dvd_reg[DW-2:0], ge};

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        dur_next   = dur_reg;
        pop        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    dvd_next = DW'(head.ticks) << DUR_FRAC_BITS;
                    rem_next = 32'd0;
                    cnt_next = '0;
                    if (!head.has_seg)
                        state_next = B_FIN;
                    else if (head.scale == 32'd0)
                    begin
                        dur_next   = '1;
                        state_next = B_SEG;
                    end
                    else
                        state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next = ge ? 32'(rem_sh - {1'b0, cmd_reg.scale}) : rem_sh[31:0];
                dvd_next = q_last;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    dur_next   = (|(q_last >> OW)) ? '1 : OW'(q_last);
                    state_next = B_SEG;
                end
            end
            B_SEG:
            begin
                if (out_ready)
                    state_next = cmd_reg.has_fin ? B_FIN : B_IDLE;
            end
            default:
            begin
                if (out_ready)
                    state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid     = state_reg == B_SEG || state_reg == B_FIN;
        record_kind   = (state_reg == B_FIN) ? msidx_pkg::KIND_FINISH : msidx_pkg::KIND_SEGMENT;
        seg_begin     = (state_reg == B_SEG) ? cmd_reg.seg_begin : 64'd0;
        seg_length    = (state_reg == B_SEG) ? cmd_reg.seg_length : 31'd0;
        seg_duration  = (state_reg == B_SEG) ? dur_reg : 48'd0;
        movie_end_pos = (state_reg == B_FIN) ? cmd_reg.movie_end : 64'd0;
        is_last       = state_reg == B_FIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dur_reg <= dur_next;
    end

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> cnt_reg < CW'(DW))
        else $error("divider ran past its last step");
    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SEG && cmd_reg.scale == 32'd0) |-> dur_reg == '1)
        else $error("zero timescale did not saturate the duration");
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_FIN && out_ready) |=> state_reg == B_IDLE)
        else $error("end record transaction did not release the back end");
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DIV |-> rem_reg < cmd_reg.scale)
        else $error("divider remainder not below the timescale");

endmodule

`default_nettype wire
